/* rtl/mid_pkg.sv */
// ----------------------------------------------------------------------------
// mid_pkg: shared definitions for the minimum image distance block
// Default widths, register indexes and boundary mode codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mid_pkg;

   // default coordinate format: signed Q12.12 in 24 bits
   localparam int COORD_BITS_DEFAULT = 24;
   localparam int FRAC_BITS_DEFAULT  = 12;

   // box length after reset, in whole units (64.0)
   localparam int BOX_RESET_UNITS = 64;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOUNDARY_MODE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOX_LENGTH_X  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOX_LENGTH_Y  = 2'd2;

   // boundary modes; the unused code behaves as open
   localparam int MODE_BITS = 2;
   localparam logic [MODE_BITS-1:0] MODE_PERIODIC = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_STRIP    = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_OPEN     = 2'd2;

endpackage : mid_pkg

`default_nettype wire

/* rtl/mid_sqrt_pipe.sv */
// ----------------------------------------------------------------------------
// mid_sqrt_pipe: pipelined integer square root
// Restoring digit-by-digit root, one root bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mid_sqrt_pipe
   import mid_pkg::*;
#(
   parameter int ROOT_BITS = COORD_BITS_DEFAULT + 1
) (
   input  wire logic                   clock,
   input  wire logic [ROOT_BITS-1:0]   stage_en,
   input  wire logic [ROOT_BITS-1:0]   stage_valid,
   input  wire logic [2*ROOT_BITS-1:0] radicand,
   output logic      [ROOT_BITS-1:0]   root
);

   localparam int RAD_BITS = 2 * ROOT_BITS;
   localparam int REM_BITS = ROOT_BITS + 2;

   logic [RAD_BITS-1:0]  rad_ff  [ROOT_BITS-1];
   logic [REM_BITS-1:0]  rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];

   for (genvar s = 0; s < ROOT_BITS; s++) begin : g_stage
      logic [RAD_BITS-1:0]  rad_src;
      logic [REM_BITS-1:0]  rem_src;
      logic [ROOT_BITS-1:0] root_src;
      logic [REM_BITS-1:0]  rem_shift;
      logic [REM_BITS-1:0]  trial;
      logic                 take;

      // select the previous stage, or the radicand for the first one
      if (s == 0) begin : g_first
         assign rad_src  = radicand;
         assign rem_src  = '0;
         assign root_src = '0;
      end else begin : g_next
         assign rad_src  = rad_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign root_src = root_ff[s-1];
      end

      // bring down the next pair of radicand bits and try the new root bit
      always_comb begin
         rem_shift = {rem_src[REM_BITS-3:0], rad_src[RAD_BITS-1 -: 2]};
         trial     = {root_src, 2'b01};
         take      = (rem_shift >= trial);
      end

      // advance remainder and partial root
      always_ff @(posedge clock) begin
         if (stage_en[s]) begin
            if (take) begin
               rem_ff[s]  <= rem_shift - trial;
               root_ff[s] <= {root_src[ROOT_BITS-2:0], 1'b1};
            end else begin
               rem_ff[s]  <= rem_shift;
               root_ff[s] <= {root_src[ROOT_BITS-2:0], 1'b0};
            end
         end
      end

      // carry the unused radicand bits, not needed after the last stage
      if (s < ROOT_BITS - 1) begin : g_rad
         always_ff @(posedge clock) begin
            if (stage_en[s]) begin
               rad_ff[s] <= rad_src << 2;
            end
         end
      end
   end

   assign root = root_ff[ROOT_BITS-1];

`ifndef SYNTHESIS
   // the final remainder never exceeds twice the root
   a_final_rem : assert property (@(posedge clock)
      stage_valid[ROOT_BITS-1] |->
         (rem_ff[ROOT_BITS-1] <= {1'b0, root_ff[ROOT_BITS-1], 1'b0}))
      else $error("sqrt remainder exceeds twice the root");

   // after one step the partial root holds a single bit
   a_first_root : assert property (@(posedge clock)
      stage_valid[0] |-> (root_ff[0] <= ROOT_BITS'(1)))
      else $error("first sqrt stage root out of range");

   // a stage holding its data keeps its remainder
   a_hold_rem : assert property (@(posedge clock)
      stage_valid[1] && !stage_en[1] |=> $stable(rem_ff[1]))
      else $error("sqrt stage lost its remainder while held");
`endif

endmodule : mid_sqrt_pipe

`default_nettype wire

/* rtl/minimum_image_distance.sv */
// ----------------------------------------------------------------------------
// minimum_image_distance: wrapped Euclidean distance of two 2-D points
// Per-axis difference, minimum-image wrap, squares, sum and a pipelined
// integer square root; result is floor(sqrt(dx^2 + dy^2)) in unsigned Q13.12.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    first_x, first_y, second_x, second_y
//  rsp      out        rsp_valid/stall    distance
//  csr      in         csr_valid/ready    csr_index, csr_wdata
//
//  One transaction enters per cycle while the input is not stalled; each one
//  passes the front-end stages and then the one-bit-per-stage square root.
//  Reset clears all stage valid bits and loads the configuration defaults;
//  while reset is high the input stalls and register writes are not taken.
//  A stalled result holds only the stages behind it that are full; empty
//  stages keep filling, so input stalls only when every stage is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module minimum_image_distance
   import mid_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,

   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [COORD_BITS-1:0] req_first_x,
   input  wire logic signed [COORD_BITS-1:0] req_first_y,
   input  wire logic signed [COORD_BITS-1:0] req_second_x,
   input  wire logic signed [COORD_BITS-1:0] req_second_y,

   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic             [COORD_BITS:0]   rsp_distance,

   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [COORD_BITS-1:0]        csr_wdata
);

   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int WRAP_BITS  = COORD_BITS + 3;
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int SUM_BITS   = SQ_BITS + 1;
   localparam int ROOT_BITS  = COORD_BITS + 1;
   localparam int RAD_BITS   = 2 * ROOT_BITS;
   localparam int PRE_STAGES = 6;
   localparam int NUM_STAGES = PRE_STAGES + ROOT_BITS;
   localparam logic [COORD_BITS-1:0] BOX_RESET = COORD_BITS'(BOX_RESET_UNITS << FRAC_BITS);

   // stage numbers of the front end
   localparam int ST_DIFF   = 0;
   localparam int ST_WRAP1  = 1;
   localparam int ST_WRAP2  = 2;
   localparam int ST_ABS    = 3;
   localparam int ST_SQUARE = 4;
   localparam int ST_SUM    = 5;

   // configuration registers
   logic [MODE_BITS-1:0]  boundary_mode_ff;
   logic [COORD_BITS-1:0] box_length_x_ff;
   logic [COORD_BITS-1:0] box_length_y_ff;

   // pipeline control
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] stage_en;

   // datapath
   logic signed [WRAP_BITS-1:0] len_x, len_y;
   logic                        wrap_x, wrap_y;
   logic signed [DIFF_BITS-1:0] dx0_ff, dy0_ff;
   logic signed [WRAP_BITS-1:0] dx0_ext, dy0_ext;
   logic signed [WRAP_BITS-1:0] dx1_in, dy1_in, dx1_ff, dy1_ff;
   logic signed [WRAP_BITS-1:0] dx2_in, dy2_in, dx2_ff, dy2_ff;
   logic signed [WRAP_BITS-1:0] dx2_neg, dy2_neg;
   logic [COORD_BITS-1:0]       ax_in, ay_in, ax_ff, ay_ff;
   logic [SQ_BITS-1:0]          sq_x_ff, sq_y_ff;
   logic [SUM_BITS-1:0]         sum_ff;
   logic [ROOT_BITS-1:0]        root;

   // take register writes whenever out of reset
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         boundary_mode_ff <= MODE_PERIODIC;
         box_length_x_ff  <= BOX_RESET;
         box_length_y_ff  <= BOX_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BOUNDARY_MODE: boundary_mode_ff <= csr_wdata[MODE_BITS-1:0];
            CSR_BOX_LENGTH_X:  box_length_x_ff  <= csr_wdata;
            CSR_BOX_LENGTH_Y:  box_length_y_ff  <= csr_wdata;
            default: begin
               // no register at this index: drop the write
            end
         endcase
      end
   end

   // a stage advances when it is empty or the stage after it advances
   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      for (int i = 0; i < NUM_STAGES; i++) begin
         if (stage_en[i]) begin
            valid_in[i] = (i == 0) ? req_valid : valid_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold off the input during reset and while the first stage is blocked
   assign req_stall = reset || !stage_en[ST_DIFF];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   // per-axis wrap enables and box lengths widened for signed compares
   always_comb begin
      wrap_x = (boundary_mode_ff == MODE_PERIODIC) || (boundary_mode_ff == MODE_STRIP);
      wrap_y = (boundary_mode_ff == MODE_PERIODIC);
      len_x  = WRAP_BITS'(box_length_x_ff);
      len_y  = WRAP_BITS'(box_length_y_ff);
   end

   // stage: coordinate differences, first minus second
   always_ff @(posedge clock) begin
      if (stage_en[ST_DIFF]) begin
         dx0_ff <= {req_first_x[COORD_BITS-1], req_first_x}
                 - {req_second_x[COORD_BITS-1], req_second_x};
         dy0_ff <= {req_first_y[COORD_BITS-1], req_first_y}
                 - {req_second_y[COORD_BITS-1], req_second_y};
      end
   end

   // stage: subtract the box length when 2d exceeds it
   always_comb begin
      dx0_ext = WRAP_BITS'(dx0_ff);
      dy0_ext = WRAP_BITS'(dy0_ff);
      dx1_in  = (wrap_x && ((dx0_ext <<< 1) > len_x)) ? dx0_ext - len_x : dx0_ext;
      dy1_in  = (wrap_y && ((dy0_ext <<< 1) > len_y)) ? dy0_ext - len_y : dy0_ext;
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_WRAP1]) begin
         dx1_ff <= dx1_in;
         dy1_ff <= dy1_in;
      end
   end

   // stage: add the box length when -2d reaches it
   always_comb begin
      dx2_in = (wrap_x && (-(dx1_ff <<< 1) >= len_x)) ? dx1_ff + len_x : dx1_ff;
      dy2_in = (wrap_y && (-(dy1_ff <<< 1) >= len_y)) ? dy1_ff + len_y : dy1_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_WRAP2]) begin
         dx2_ff <= dx2_in;
         dy2_ff <= dy2_in;
      end
   end

   // stage: magnitudes; they always fit the coordinate width as unsigned values
   always_comb begin
      dx2_neg = -dx2_ff;
      dy2_neg = -dy2_ff;
      ax_in   = dx2_ff[WRAP_BITS-1] ? dx2_neg[COORD_BITS-1:0] : dx2_ff[COORD_BITS-1:0];
      ay_in   = dy2_ff[WRAP_BITS-1] ? dy2_neg[COORD_BITS-1:0] : dy2_ff[COORD_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_ABS]) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
      end
   end

   // stage: squares
   always_ff @(posedge clock) begin
      if (stage_en[ST_SQUARE]) begin
         sq_x_ff <= SQ_BITS'(ax_ff) * SQ_BITS'(ax_ff);
         sq_y_ff <= SQ_BITS'(ay_ff) * SQ_BITS'(ay_ff);
      end
   end

   // stage: sum of squares
   always_ff @(posedge clock) begin
      if (stage_en[ST_SUM]) begin
         sum_ff <= SUM_BITS'(sq_x_ff) + SUM_BITS'(sq_y_ff);
      end
   end

   // square root, one result bit per stage; its last stage is the output
   mid_sqrt_pipe #(
      .ROOT_BITS (ROOT_BITS)
   ) u_sqrt (
      .clock       (clock),
      .stage_en    (stage_en[NUM_STAGES-1:PRE_STAGES]),
      .stage_valid (valid_ff[NUM_STAGES-1:PRE_STAGES]),
      .radicand    (RAD_BITS'(sum_ff)),
      .root        (root)
   );

   assign rsp_distance = root;

`ifndef SYNTHESIS
   // input waits only when every stage holds a transaction and the output is held
   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&valid_ff) && rsp_stall))
      else $error("input stalled with room in the pipeline");

   // a free output never stalls the input
   a_free_out : assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output is free");

   // reset empties the pipeline
   a_reset_empty : assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("pipeline not empty after reset");

   // a held output keeps the stage behind it from being overwritten
   a_hold_back : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && valid_ff[NUM_STAGES-2] |=> valid_ff[NUM_STAGES-2])
      else $error("transaction lost behind a held output");
`endif

endmodule : minimum_image_distance

`default_nettype wire
